// ===== hw/rtl/btd_pkg.sv =====
// Shared constants, types and state codes for the breadcrumb trail lookup block.
package btd_pkg;

    localparam int TRAIL_DEPTH = 64;
    localparam int AW          = $clog2(TRAIL_DEPTH);
    localparam int UW          = $clog2(TRAIL_DEPTH + 1);

    localparam logic [22:0] STEP_RESET = 23'd26;

    localparam logic [1:0] MODE_RESTART     = 2'd0;
    localparam logic [1:0] MODE_OFFER       = 2'd1;
    localparam logic [1:0] MODE_FROM_TARGET = 2'd2;
    localparam logic [1:0] MODE_FROM_NEWEST = 2'd3;

    localparam logic REG_STEP_DISTANCE = 1'b0;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD1,
        ST_LD2,
        ST_LD3,
        ST_WALK2,
        ST_WLD2,
        ST_WALK3,
        ST_W3LD,
        ST_W3LD2,
        ST_LMUL,
        ST_LADD,
        ST_SQRT,
        ST_LDONE,
        ST_IMUL,
        ST_ISET,
        ST_IDIV,
        ST_INEXT
    } t_state;

endpackage

// ===== hw/rtl/breadcrumb_trail_distance_lookup.sv =====
// Breadcrumb trail store with step filtering and path-distance point lookup.
//
//  channel   signals                                   handshake
//  command   i_mode i_pos_* i_flat_only i_desired_dist start && !busy
//  result    o_out_* o_stored o_used_count o_total_run o_done, one cycle
//  config    psel penable pwrite paddr pwdata prdata   APB, pready tied high
//
// Restart writes the first trail entry directly from idle. Offer: squares on the shared multiplier, then the root.
// Lookups add a walk over the trail segments and three axis divisions; the bit-serial root and
// divider and the single read port shape how long a command stays busy.
// After reset a clearing pass runs over all 64 trail memory entries; busy is high.
// Results cannot be stalled; the next command is taken in the result cycle.
module breadcrumb_trail_distance_lookup (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_mode,
    input  logic [23:0]            i_pos_x,
    input  logic [23:0]            i_pos_y,
    input  logic [23:0]            i_pos_z,
    input  logic                   i_flat_only,
    input  logic [23:0]            i_desired_distance,
    output logic                   o_done,
    output logic [23:0]            o_out_x,
    output logic [23:0]            o_out_y,
    output logic [23:0]            o_out_z,
    output logic                   o_stored,
    output logic [btd_pkg::UW-1:0] o_used_count,
    output logic [31:0]            o_total_run,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int AW = btd_pkg::AW;
    localparam int UW = btd_pkg::UW;

    btd_pkg::t_state r_state, n_state;
    logic            r_done, n_done;
    logic [AW-1:0]   r_newest, n_newest;
    logic [UW-1:0]   r_used, n_used;
    logic [31:0]     r_run, n_run;
    logic [22:0]     r_step, n_step;
    logic [AW-1:0]   r_caddr, n_caddr;

    logic [1:0]  r_mode, n_mode;
    logic [23:0] r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic        r_flat, n_flat;
    logic [23:0] r_want, n_want;
    logic [23:0] r_sx, n_sx, r_sy, n_sy, r_sz, n_sz;
    logic [23:0] r_ex, n_ex, r_ey, n_ey, r_ez, n_ez;
    logic signed [24:0] r_dx, n_dx, r_dy, n_dy, r_dz, n_dz;
    logic [1:0]  r_axis, n_axis;
    logic [50:0] r_acc, n_acc, r_res, n_res, r_bit, n_bit;
    logic [49:0] r_prod, n_prod;
    logic [4:0]  r_cnt, n_cnt;
    logic [24:0] r_seg, n_seg;
    logic signed [33:0] r_comp, n_comp;
    logic [AW-1:0] r_ip, n_ip, r_ie, n_ie, r_is, n_is;
    logic [UW-1:0] r_i, n_i;
    logic [24:0] r_num, n_num, r_den, n_den;
    logic        r_neg, n_neg;
    logic [25:0] r_rem, n_rem;
    logic [24:0] r_quo, n_quo;
    logic [23:0] r_ox, n_ox, r_oy, n_oy, r_oz, n_oz;
    logic        r_stored, n_stored;

    logic [95:0]   mem [btd_pkg::TRAIL_DEPTH];
    logic [95:0]   r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_wa, rd_addr;
    logic [95:0]   mem_wd;

    logic [24:0] mul_a, mul_b;
    logic [49:0] mul_p;
    logic        cfg_wr;

    function automatic logic signed [24:0] sx25(input logic [23:0] v);
        return $signed({v[23], v});
    endfunction

    function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] i);
        return (i == '0) ? AW'(btd_pkg::TRAIL_DEPTH - 1) : i - AW'(1);
    endfunction

    function automatic logic [23:0] pick3(input logic [1:0] a, input logic [23:0] x,
                                          input logic [23:0] y, input logic [23:0] z);
        unique case (a)
            2'd0:    return x;
            2'd1:    return y;
            default: return z;
        endcase
    endfunction

    // single shared multiplier: squares for lengths, magnitude times fraction for lerp
    assign mul_p = mul_a * mul_b;

    assign busy         = (r_state != btd_pkg::ST_IDLE);
    assign o_done       = r_done;
    assign o_out_x      = r_ox;
    assign o_out_y      = r_oy;
    assign o_out_z      = r_oz;
    assign o_stored     = r_stored;
    assign o_used_count = r_used;
    assign o_total_run  = r_run;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == btd_pkg::REG_STEP_DISTANCE) ? {9'd0, r_step} : 32'd0;
    assign cfg_wr       = psel && penable && pwrite;

    always_comb begin
        logic [23:0] rd_x, rd_y, rd_z, rd_seg;
        logic [24:0] len, mag;
        logic signed [24:0] dsel, base, tow;
        logic signed [25:0] w26, ores;
        logic [50:0] tsum, dvd;
        logic [26:0] tdiv, dvs;
        logic signed [33:0] want34, cdiff;
        logic signed [34:0] nm;
        logic [32:0] runsum;
        logic [AW-1:0] nxt, pip;

        rd_x   = r_rd[95:72];
        rd_y   = r_rd[71:48];
        rd_z   = r_rd[47:24];
        rd_seg = r_rd[23:0];
        len    = r_res[24:0];
        want34 = $signed({{10{r_want[23]}}, r_want});
        w26    = $signed({{2{r_want[23]}}, r_want});
        cdiff  = r_comp - want34;
        nm     = $signed({10'd0, r_seg}) - $signed({cdiff[33], cdiff});
        runsum = {1'b0, r_run} + 33'(len);
        nxt    = (r_newest == AW'(btd_pkg::TRAIL_DEPTH - 1)) ? '0 : r_newest + AW'(1);
        pip    = prev_idx(r_ip);
        dsel   = (r_axis == 2'd0) ? r_dx : ((r_axis == 2'd1) ? r_dy : r_dz);
        base   = sx25(pick3(r_axis, r_sx, r_sy, r_sz));
        tow    = sx25(pick3(r_axis, r_ex, r_ey, r_ez));
        mag    = '0;
        tsum   = r_res + r_bit;
        dvd    = {r_prod, 1'b0} + 51'(r_den);
        tdiv   = {r_rem, r_quo[24]};
        dvs    = {1'b0, r_den, 1'b0};
        ores   = '0;

        n_state = r_state; n_done = 1'b0; n_newest = r_newest; n_used = r_used;
        n_run = r_run; n_step = r_step; n_caddr = r_caddr;
        n_mode = r_mode; n_px = r_px; n_py = r_py; n_pz = r_pz; n_flat = r_flat;
        n_want = r_want; n_sx = r_sx; n_sy = r_sy; n_sz = r_sz;
        n_ex = r_ex; n_ey = r_ey; n_ez = r_ez; n_dx = r_dx; n_dy = r_dy; n_dz = r_dz;
        n_axis = r_axis; n_acc = r_acc; n_res = r_res; n_bit = r_bit; n_prod = r_prod;
        n_cnt = r_cnt; n_seg = r_seg; n_comp = r_comp; n_ip = r_ip; n_ie = r_ie;
        n_is = r_is; n_i = r_i; n_num = r_num; n_den = r_den; n_neg = r_neg;
        n_rem = r_rem; n_quo = r_quo; n_ox = r_ox; n_oy = r_oy; n_oz = r_oz;
        n_stored = r_stored;
        mem_we = 1'b0; mem_wa = '0; mem_wd = '0; rd_addr = r_newest;
        mul_a = '0; mul_b = '0;

        if (cfg_wr && paddr[2] == btd_pkg::REG_STEP_DISTANCE) begin
            n_step = pwdata[22:0];
        end

        unique case (r_state)
            btd_pkg::ST_CLEAR: begin
                mem_we  = 1'b1;
                mem_wa  = r_caddr;
                n_caddr = r_caddr + AW'(1);
                if (r_caddr == AW'(btd_pkg::TRAIL_DEPTH - 1)) begin
                    n_state = btd_pkg::ST_IDLE;
                end
            end
            btd_pkg::ST_IDLE: begin
                if (start) begin
                    n_mode = i_mode; n_px = i_pos_x; n_py = i_pos_y; n_pz = i_pos_z;
                    n_flat = i_flat_only; n_want = i_desired_distance;
                    n_ox = '0; n_oy = '0; n_oz = '0; n_stored = 1'b0;
                    unique case (i_mode)
                        btd_pkg::MODE_RESTART: begin
                            mem_we   = 1'b1;
                            mem_wa   = '0;
                            mem_wd   = {i_pos_x, i_pos_y, i_pos_z, 24'd0};
                            n_newest = '0;
                            n_used   = UW'(1);
                            n_run    = '0;
                            n_done   = 1'b1;
                        end
                        btd_pkg::MODE_OFFER: n_state = btd_pkg::ST_LD1;
                        btd_pkg::MODE_FROM_TARGET: begin
                            if (r_used == '0) begin
                                n_ox = i_pos_x; n_oy = i_pos_y; n_oz = i_pos_z;
                                n_done = 1'b1;
                            end else begin
                                n_state = btd_pkg::ST_LD2;
                            end
                        end
                        default: begin
                            if (r_used == '0) begin
                                n_done = 1'b1;
                            end else if (r_used < UW'(2) || i_desired_distance[23]
                                         || i_desired_distance == '0) begin
                                n_state = btd_pkg::ST_LD3;
                            end else begin
                                n_ie = r_newest; n_is = prev_idx(r_newest); n_i = '0;
                                n_state = btd_pkg::ST_WALK3;
                            end
                        end
                    endcase
                end
            end
            btd_pkg::ST_LD1, btd_pkg::ST_LD2: begin
                n_ex = rd_x; n_ey = rd_y; n_ez = rd_z;
                n_sx = r_px; n_sy = r_py; n_sz = r_pz;
                n_dx = sx25(r_px) - sx25(rd_x);
                n_dy = sx25(r_py) - sx25(rd_y);
                n_dz = (r_state == btd_pkg::ST_LD1 && r_flat) ? '0 : sx25(r_pz) - sx25(rd_z);
                n_acc = '0; n_axis = '0; n_state = btd_pkg::ST_LMUL;
            end
            btd_pkg::ST_LD3: begin
                n_ox = rd_x; n_oy = rd_y; n_oz = rd_z;
                n_done = 1'b1; n_state = btd_pkg::ST_IDLE;
            end
            btd_pkg::ST_WALK2: begin
                if (r_i + UW'(1) < r_used) begin
                    n_ip = pip;
                    if (r_comp >= want34 && r_seg != '0) begin
                        n_num = nm[34] ? '0 : nm[24:0];
                        n_den = r_seg; n_axis = '0; n_state = btd_pkg::ST_IMUL;
                    end else begin
                        rd_addr = pip; n_state = btd_pkg::ST_WLD2;
                    end
                end else begin
                    n_ox = r_ex; n_oy = r_ey; n_oz = r_ez;
                    n_done = 1'b1; n_state = btd_pkg::ST_IDLE;
                end
            end
            btd_pkg::ST_WLD2: begin
                n_sx = r_ex; n_sy = r_ey; n_sz = r_ez;
                n_ex = rd_x; n_ey = rd_y; n_ez = rd_z;
                n_seg = 25'(rd_seg);
                n_comp = r_comp + $signed({10'd0, rd_seg});
                n_i = r_i + UW'(1);
                n_state = btd_pkg::ST_WALK2;
            end
            btd_pkg::ST_WALK3: begin
                if (r_i + UW'(1) < r_used) begin
                    rd_addr = r_ie; n_state = btd_pkg::ST_W3LD;
                end else begin
                    // walk ran out: end point of the last segment seen
                    n_ox = r_sx; n_oy = r_sy; n_oz = r_sz;
                    n_done = 1'b1; n_state = btd_pkg::ST_IDLE;
                end
            end
            btd_pkg::ST_W3LD: begin
                n_sx = rd_x; n_sy = rd_y; n_sz = rd_z;
                if (w26 > $signed({2'b00, rd_seg})) begin
                    n_want = r_want - rd_seg;
                    n_ie = r_is; n_is = prev_idx(r_is); n_i = r_i + UW'(1);
                    n_state = btd_pkg::ST_WALK3;
                end else begin
                    rd_addr = r_is; n_state = btd_pkg::ST_W3LD2;
                end
            end
            btd_pkg::ST_W3LD2: begin
                n_ex = rd_x; n_ey = rd_y; n_ez = rd_z;
                n_dx = sx25(r_sx) - sx25(rd_x);
                n_dy = sx25(r_sy) - sx25(rd_y);
                n_dz = sx25(r_sz) - sx25(rd_z);
                n_acc = '0; n_axis = '0; n_state = btd_pkg::ST_LMUL;
            end
            btd_pkg::ST_LMUL: begin
                mag    = dsel[24] ? 25'(-dsel) : 25'(dsel);
                mul_a  = mag; mul_b = mag;
                n_prod = mul_p;
                n_state = btd_pkg::ST_LADD;
            end
            btd_pkg::ST_LADD: begin
                n_acc = r_acc + 51'(r_prod);
                if (r_axis == 2'd2) begin
                    n_res = '0; n_bit = 51'(1) << 48; n_cnt = 5'd24;
                    n_state = btd_pkg::ST_SQRT;
                end else begin
                    n_axis = r_axis + 2'd1; n_state = btd_pkg::ST_LMUL;
                end
            end
            btd_pkg::ST_SQRT: begin
                if (r_acc >= tsum) begin
                    n_acc = r_acc - tsum;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = btd_pkg::ST_LDONE;
                end
            end
            btd_pkg::ST_LDONE: begin
                unique case (r_mode)
                    btd_pkg::MODE_FROM_TARGET: begin
                        n_seg = len; n_comp = $signed({9'd0, len});
                        n_ip = r_newest; n_i = '0; n_state = btd_pkg::ST_WALK2;
                    end
                    btd_pkg::MODE_FROM_NEWEST: begin
                        if (len == '0) begin
                            n_ox = r_sx; n_oy = r_sy; n_oz = r_sz;
                            n_done = 1'b1; n_state = btd_pkg::ST_IDLE;
                        end else begin
                            n_num = (w26 < $signed({1'b0, len})) ? 25'(r_want) : len;
                            n_den = len; n_axis = '0; n_state = btd_pkg::ST_IMUL;
                        end
                    end
                    default: begin
                        if (len >= 25'(r_step)) begin
                            mem_we   = 1'b1;
                            mem_wa   = nxt;
                            mem_wd   = {r_px, r_py, r_pz, len[24] ? 24'hFFFFFF : len[23:0]};
                            n_newest = nxt;
                            n_run    = runsum[32] ? 32'hFFFFFFFF : runsum[31:0];
                            if (r_used < UW'(btd_pkg::TRAIL_DEPTH)) begin
                                n_used = r_used + UW'(1);
                            end
                            n_stored = 1'b1;
                        end
                        n_done = 1'b1; n_state = btd_pkg::ST_IDLE;
                    end
                endcase
            end
            btd_pkg::ST_IMUL: begin
                dsel   = tow - base;
                n_neg  = dsel[24];
                mag    = dsel[24] ? 25'(-dsel) : 25'(dsel);
                mul_a  = mag; mul_b = r_num;
                n_prod = mul_p;
                n_state = btd_pkg::ST_ISET;
            end
            btd_pkg::ST_ISET: begin
                // round to nearest: (2*mag*num + den) / (2*den)
                n_rem = dvd[50:25]; n_quo = dvd[24:0]; n_cnt = 5'd24;
                n_state = btd_pkg::ST_IDIV;
            end
            btd_pkg::ST_IDIV: begin
                if (tdiv >= dvs) begin
                    n_rem = 26'(tdiv - dvs);
                    n_quo = {r_quo[23:0], 1'b1};
                end else begin
                    n_rem = tdiv[25:0];
                    n_quo = {r_quo[23:0], 1'b0};
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = btd_pkg::ST_INEXT;
                end
            end
            btd_pkg::ST_INEXT: begin
                ores = r_neg ? $signed({base[24], base}) - $signed({1'b0, r_quo})
                             : $signed({base[24], base}) + $signed({1'b0, r_quo});
                unique case (r_axis)
                    2'd0:    n_ox = ores[23:0];
                    2'd1:    n_oy = ores[23:0];
                    default: n_oz = ores[23:0];
                endcase
                if (r_axis == 2'd2) begin
                    n_done = 1'b1; n_state = btd_pkg::ST_IDLE;
                end else begin
                    n_axis = r_axis + 2'd1; n_state = btd_pkg::ST_IMUL;
                end
            end
            default: n_state = btd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= btd_pkg::ST_CLEAR;
            r_done   <= 1'b0;
            r_newest <= '0;
            r_used   <= '0;
            r_run    <= '0;
            r_step   <= btd_pkg::STEP_RESET;
            r_caddr  <= '0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_newest <= n_newest;
            r_used   <= n_used;
            r_run    <= n_run;
            r_step   <= n_step;
            r_caddr  <= n_caddr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode; r_px <= n_px; r_py <= n_py; r_pz <= n_pz; r_flat <= n_flat;
        r_want <= n_want; r_sx <= n_sx; r_sy <= n_sy; r_sz <= n_sz;
        r_ex <= n_ex; r_ey <= n_ey; r_ez <= n_ez; r_dx <= n_dx; r_dy <= n_dy; r_dz <= n_dz;
        r_axis <= n_axis; r_acc <= n_acc; r_res <= n_res; r_bit <= n_bit; r_prod <= n_prod;
        r_cnt <= n_cnt; r_seg <= n_seg; r_comp <= n_comp; r_ip <= n_ip; r_ie <= n_ie;
        r_is <= n_is; r_i <= n_i; r_num <= n_num; r_den <= n_den; r_neg <= n_neg;
        r_rem <= n_rem; r_quo <= n_quo; r_ox <= n_ox; r_oy <= n_oy; r_oz <= n_oz;
        r_stored <= n_stored;
    end

    // trail memory: {x, y, z, segment length}, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/btd_checker.sv =====
// Port-level checks for the breadcrumb trail lookup block, bound to the top level.
module btd_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_done,
    input logic                   o_stored,
    input logic [btd_pkg::UW-1:0] o_used_count
);

    // a result cycle always leaves the block free for the next command
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result strobe while busy");

    // an accepted command either finishes at once or holds busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done)) else $error("command dropped");

    // no result without a command in flight
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy || start)) else $error("spurious result");

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_stored) |-> (o_used_count != '0
            && o_used_count <= btd_pkg::UW'(btd_pkg::TRAIL_DEPTH)))
        else $error("trail count out of range after store");

endmodule

bind breadcrumb_trail_distance_lookup btd_checker u_btd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_stored     (o_stored),
    .o_used_count (o_used_count)
);
